// ===== sv/alpe_pkg.sv =====
// Package for the addressable LED pulse encoder.
// Holds the configuration and command types, register index codes and fixed sizes.
// Used by the front end, queue, serializer and top level; depends on nothing else.
`timescale 1ns / 1ps

package alpe_pkg;

  // Bit slots sent for one LED: green, red, blue, eight bits each.
  localparam int SLOTS_PER_LED = 24;
  localparam int SLOT_CNT_W    = 5;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 8;
  localparam int RES_CNT_W     = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LEVEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_SLOTS = 3'd4;

  // Scale mode codes.
  localparam logic MODE_ALPHA_TIMES_GLOBAL = 1'b0;
  localparam logic MODE_GLOBAL_FIRST       = 1'b1;

  // Register values after reset.
  localparam logic [7:0]           RST_BASE_LEVEL  = 8'd30;
  localparam logic                 RST_SCALE_MODE  = MODE_ALPHA_TIMES_GLOBAL;
  localparam logic [7:0]           RST_ONE_WIDTH   = 8'd48;
  localparam logic [7:0]           RST_ZERO_WIDTH  = 8'd24;
  localparam logic [RES_CNT_W-1:0] RST_RESET_SLOTS = 6'd40;

  typedef struct packed {
    logic [7:0]           base_level;
    logic                 scale_mode;
    logic [7:0]           one_width;
    logic [7:0]           zero_width;
    logic [RES_CNT_W-1:0] reset_slots;
  } alpe_cfg_t;

  // One classified LED: the scaled GRB word and the reset gap that follows it.
  typedef struct packed {
    logic [SLOTS_PER_LED-1:0] word;
    logic [RES_CNT_W-1:0]     nres;
  } alpe_cmd_t;

endpackage

// ===== sv/alpe_front.sv =====
// Front end of the LED pulse encoder: accepts colour items, picks the brightness,
// scales the channels and forms the GRB word with its reset gap length.
// Depends on alpe_pkg.
`timescale 1ns / 1ps

module alpe_front #(
  parameter int LED_COUNT       = 8,
  parameter int MAX_RESET_SLOTS = 40
) (
  input  logic                clk,
  input  logic                rst_n,
  input  alpe_pkg::alpe_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_led_index,
  input  logic [7:0]          in_red,
  input  logic [7:0]          in_green,
  input  logic [7:0]          in_blue,
  input  logic [7:0]          in_alpha,
  output logic                cmd_valid,
  output alpe_pkg::alpe_cmd_t cmd,
  input  logic                cmd_ready
);
  import alpe_pkg::*;

  localparam logic [RES_CNT_W-1:0] MaxRes = RES_CNT_W'(MAX_RESET_SLOTS);

  logic                 s1_v_r;
  logic [7:0]           s1_red_r;
  logic [7:0]           s1_green_r;
  logic [7:0]           s1_blue_r;
  logic [7:0]           s1_bright_r;
  logic                 s1_scale_r;
  logic [RES_CNT_W-1:0] s1_nres_r;
  logic                 s2_v_r;
  alpe_cmd_t            s2_cmd_r;

  logic                 s1_ready;
  logic                 s2_ready;
  logic                 in_acc;
  logic [15:0]          prod_ag;
  logic [7:0]           bright;
  logic                 do_scale;
  logic                 ends;
  logic [RES_CNT_W-1:0] nres_sat;
  logic [15:0]          prod_r;
  logic [15:0]          prod_g;
  logic [15:0]          prod_b;
  logic [7:0]           sc_red;
  logic [7:0]           sc_green;
  logic [7:0]           sc_blue;

  // Stall chain from the queue back to the input.
  assign s2_ready = !s2_v_r || cmd_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;
  assign in_acc   = in_valid && in_ready;

  // Brightness selection by scale mode.
  assign prod_ag = in_alpha * cfg.base_level;
  always_comb begin
    bright   = 8'd0;
    do_scale = 1'b1;
    if (cfg.scale_mode == MODE_ALPHA_TIMES_GLOBAL) begin
      priority if (in_alpha != 8'd0) begin
        bright = prod_ag[15:8];
      end else if (cfg.base_level != 8'd0) begin
        bright = cfg.base_level;
      end else begin
        do_scale = 1'b0;
      end
    end else begin
      priority if (cfg.base_level != 8'd0) begin
        bright = cfg.base_level;
      end else if (in_alpha != 8'd0) begin
        bright = in_alpha;
      end else begin
        do_scale = 1'b0;
      end
    end
  end

  // The last chain position, or any past it, ends the frame with a reset gap.
  assign ends     = (int'(in_led_index) + 1) >= LED_COUNT;
  assign nres_sat = !ends ? '0 :
                    (cfg.reset_slots > MaxRes) ? MaxRes : cfg.reset_slots;

  // Stage one registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= in_valid;
    end
    if (in_acc) begin
      s1_red_r    <= in_red;
      s1_green_r  <= in_green;
      s1_blue_r   <= in_blue;
      s1_bright_r <= bright;
      s1_scale_r  <= do_scale;
      s1_nres_r   <= nres_sat;
    end
  end

  // Channel scaling.
  assign prod_r   = s1_red_r * s1_bright_r;
  assign prod_g   = s1_green_r * s1_bright_r;
  assign prod_b   = s1_blue_r * s1_bright_r;
  assign sc_red   = s1_scale_r ? prod_r[15:8] : s1_red_r;
  assign sc_green = s1_scale_r ? prod_g[15:8] : s1_green_r;
  assign sc_blue  = s1_scale_r ? prod_b[15:8] : s1_blue_r;

  // Stage two registers hold the finished command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_v_r;
    end
    if (s2_ready && s1_v_r) begin
      s2_cmd_r.word <= {sc_green, sc_red, sc_blue};
      s2_cmd_r.nres <= s1_nres_r;
    end
  end

  assign cmd_valid = s2_v_r;
  assign cmd       = s2_cmd_r;

endmodule

// ===== sv/alpe_queue.sv =====
// Two-entry command queue between the front end and the slot serializer.
// Depends on alpe_pkg.
`timescale 1ns / 1ps

module alpe_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  alpe_pkg::alpe_cmd_t push_cmd,
  output logic                pop_valid,
  input  logic                pop,
  output alpe_pkg::alpe_cmd_t pop_cmd
);
  import alpe_pkg::*;

  alpe_cmd_t  mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_cmd    = mem_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/alpe_back.sv =====
// Slot serializer of the LED pulse encoder: turns each command into 24 duty codes,
// MSB first, then the zero-duty reset slots, through a registered output.
// Depends on alpe_pkg.
`timescale 1ns / 1ps

module alpe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  alpe_pkg::alpe_cfg_t cfg,
  input  logic                cmd_valid,
  input  alpe_pkg::alpe_cmd_t cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_pulse_width,
  output logic                out_is_reset_slot,
  output logic                out_last
);
  import alpe_pkg::*;

  localparam logic [SLOT_CNT_W-1:0] LastBit = SLOT_CNT_W'(SLOTS_PER_LED - 1);

  logic                     cur_v_r;
  logic                     in_res_r;
  logic [SLOTS_PER_LED-1:0] shift_r;
  logic [SLOT_CNT_W-1:0]    bit_cnt_r;
  logic [RES_CNT_W-1:0]     res_left_r;
  logic                     out_valid_r;
  logic [7:0]               pw_r;
  logic                     rs_r;
  logic                     last_r;

  logic                     out_free;
  logic                     emit;
  logic                     slot_last;
  logic [7:0]               slot_pw;

  assign out_free = !out_valid_r || out_ready;
  assign emit     = cur_v_r && out_free;

  // Contents of the slot being sent now.
  always_comb begin
    if (in_res_r) begin
      slot_pw   = 8'd0;
      slot_last = (res_left_r == RES_CNT_W'(1));
    end else begin
      slot_pw   = shift_r[SLOTS_PER_LED-1] ? cfg.one_width : cfg.zero_width;
      slot_last = (bit_cnt_r == LastBit) && (res_left_r == '0);
    end
  end

  // A new command loads when idle or as the current one sends its final slot.
  assign cmd_pop = cmd_valid && (!cur_v_r || (emit && slot_last));

  // Walk the bit slots, then the reset slots.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
    end else if (cmd_pop) begin
      cur_v_r <= 1'b1;
    end else if (emit && slot_last) begin
      cur_v_r <= 1'b0;
    end
    if (cmd_pop) begin
      in_res_r   <= 1'b0;
      shift_r    <= cmd.word;
      bit_cnt_r  <= '0;
      res_left_r <= cmd.nres;
    end else if (emit) begin
      if (in_res_r) begin
        res_left_r <= res_left_r - RES_CNT_W'(1);
      end else begin
        shift_r   <= {shift_r[SLOTS_PER_LED-2:0], 1'b0};
        bit_cnt_r <= bit_cnt_r + SLOT_CNT_W'(1);
        if (bit_cnt_r == LastBit) begin
          in_res_r <= 1'b1;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (emit) begin
      pw_r   <= slot_pw;
      rs_r   <= in_res_r;
      last_r <= slot_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pulse_width   = pw_r;
  assign out_is_reset_slot = rs_r;
  assign out_last          = last_r;

endmodule

// ===== sv/addressable_led_pulse_encoder.sv =====
// Addressable LED pulse encoder: each colour item gives 24 GRB duty codes, plus the
// reset gap after the LED that ends the chain. An item passes the front-end stage
// registers, the queue, and the serializer's output register, which sends one slot a
// cycle unless out_ready stalls it. Two commands queue ahead.
// Synchronous active-low reset empties all stages and loads the register defaults.
`timescale 1ns / 1ps

module addressable_led_pulse_encoder #(
  parameter int LED_COUNT       = 8,
  parameter int MAX_RESET_SLOTS = 40
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [alpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [alpe_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       in_led_index,
  input  logic [7:0]                       in_red,
  input  logic [7:0]                       in_green,
  input  logic [7:0]                       in_blue,
  input  logic [7:0]                       in_alpha,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_pulse_width,
  output logic                             out_is_reset_slot,
  output logic                             out_last
);
  import alpe_pkg::*;

  alpe_cfg_t cfg_r;
  logic      cmd_valid;
  logic      cmd_ready;
  alpe_cmd_t cmd;
  logic      q_valid;
  logic      q_pop;
  alpe_cmd_t q_cmd;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_level  <= RST_BASE_LEVEL;
      cfg_r.scale_mode  <= RST_SCALE_MODE;
      cfg_r.one_width   <= RST_ONE_WIDTH;
      cfg_r.zero_width  <= RST_ZERO_WIDTH;
      cfg_r.reset_slots <= RST_RESET_SLOTS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE_LEVEL:  cfg_r.base_level  <= cfg_data;
        REG_SCALE_MODE:  cfg_r.scale_mode  <= cfg_data[0];
        REG_ONE_WIDTH:   cfg_r.one_width   <= cfg_data;
        REG_ZERO_WIDTH:  cfg_r.zero_width  <= cfg_data;
        REG_RESET_SLOTS: cfg_r.reset_slots <= cfg_data[RES_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  alpe_front #(
    .LED_COUNT      (LED_COUNT),
    .MAX_RESET_SLOTS(MAX_RESET_SLOTS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_led_index(in_led_index),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .in_alpha    (in_alpha),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_ready   (cmd_ready)
  );

  alpe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(cmd_valid),
    .push_ready(cmd_ready),
    .push_cmd  (cmd),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_cmd   (q_cmd)
  );

  alpe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd_valid        (q_valid),
    .cmd              (q_cmd),
    .cmd_pop          (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pulse_width  (out_pulse_width),
    .out_is_reset_slot(out_is_reset_slot),
    .out_last         (out_last)
  );

endmodule

// ===== sv/alpe_checker.sv =====
// Port-level checks for the LED pulse encoder, bound to the top level.
// Depends on the top level's port names.
`timescale 1ns / 1ps

module alpe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_pulse_width,
  input logic       out_is_reset_slot,
  input logic       out_last
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pulse_width)
      && $stable(out_is_reset_slot) && $stable(out_last))
    else $error("stalled result changed");

  // Reset gap slots always carry zero duty.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_reset_slot |-> out_pulse_width == 8'd0)
    else $error("reset slot with nonzero duty");

  // A reset gap runs without holes until its final slot.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_is_reset_slot && !out_last
      |=> out_valid && out_is_reset_slot)
    else $error("reset gap broken");

  // Nothing is shown right after a reset cycle.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind addressable_led_pulse_encoder alpe_checker u_alpe_checker (.*);
